>>> design/rsi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsi_pkg
// Shared constants and types for the ray / segment intersection unit.
// ----------------------------------------------------------------------------
package rsi_pkg;

  localparam int COORD_WIDTH_DEF = 32;

  // threshold register
  localparam int          THR_WIDTH = 32;
  localparam logic [31:0] THR_RESET = 32'd43;

  // result status codes
  localparam logic [1:0] ST_HIT      = 2'd0;
  localparam logic [1:0] ST_PARALLEL = 2'd1;
  localparam logic [1:0] ST_MISS     = 2'd2;

  // sideband that travels with a transaction through the divider
  typedef struct packed {
    logic [1:0] status;
    logic       neg_x;
    logic       neg_y;
  } rsi_tag_t;

endpackage

>>> design/rsi_div_pipe.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsi_div_pipe
// Pipelined restoring divider, one quotient bit per stage, two lanes (x and y)
// sharing one divisor. The top quotient bit flags a quotient too large.
// ----------------------------------------------------------------------------
module rsi_div_pipe
  import rsi_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [3*COORD_WIDTH+1:0]      in_num_x,
  input  logic [3*COORD_WIDTH+1:0]      in_num_y,
  input  logic [2*COORD_WIDTH+1:0]      in_den,
  input  rsi_tag_t                      in_tag,
  input  logic signed [COORD_WIDTH-1:0] in_org_x,
  input  logic signed [COORD_WIDTH-1:0] in_org_y,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [COORD_WIDTH+1:0]        out_q_x,
  output logic [COORD_WIDTH+1:0]        out_q_y,
  output rsi_tag_t                      out_tag,
  output logic signed [COORD_WIDTH-1:0] out_org_x,
  output logic signed [COORD_WIDTH-1:0] out_org_y
);

  localparam int W  = COORD_WIDTH;
  localparam int NW = 3 * W + 2;
  localparam int DW = 2 * W + 2;
  localparam int QW = W + 2;
  localparam int CW = NW + 1;

  logic [QW-1:0]        v;
  logic [QW:0]          en;
  logic [NW-1:0]        rem_x [QW];
  logic [NW-1:0]        rem_y [QW];
  logic [QW-1:0]        q_x   [QW];
  logic [QW-1:0]        q_y   [QW];
  logic [DW-1:0]        den   [QW];
  rsi_tag_t             tag   [QW];
  logic signed [W-1:0]  org_x [QW];
  logic signed [W-1:0]  org_y [QW];

  assign en[QW]   = out_ready;
  assign in_ready = en[0];

  for (genvar s = 0; s < QW; s++) begin : g_stage
    localparam int K = QW - 1 - s;

    logic                pv;
    logic [NW-1:0]       prx, pry;
    logic [QW-1:0]       pqx, pqy;
    logic [DW-1:0]       pden;
    rsi_tag_t            ptag;
    logic signed [W-1:0] pox, poy;
    logic [CW-1:0]       dsh;
    logic                gex, gey;

    if (s == 0) begin : g_src
      assign pv   = in_valid;
      assign prx  = in_num_x;
      assign pry  = in_num_y;
      assign pqx  = '0;
      assign pqy  = '0;
      assign pden = in_den;
      assign ptag = in_tag;
      assign pox  = in_org_x;
      assign poy  = in_org_y;
    end else begin : g_src
      assign pv   = v[s-1];
      assign prx  = rem_x[s-1];
      assign pry  = rem_y[s-1];
      assign pqx  = q_x[s-1];
      assign pqy  = q_y[s-1];
      assign pden = den[s-1];
      assign ptag = tag[s-1];
      assign pox  = org_x[s-1];
      assign poy  = org_y[s-1];
    end

    assign en[s] = !v[s] || en[s+1];
    // divisor aligned to this stage's quotient bit
    assign dsh = CW'(pden) << K;
    assign gex = CW'(prx) >= dsh;
    assign gey = CW'(pry) >= dsh;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[s] <= 1'b0;
      end else if (en[s]) begin
        v[s] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en[s] && pv) begin
        rem_x[s] <= gex ? prx - dsh[NW-1:0] : prx;
        rem_y[s] <= gey ? pry - dsh[NW-1:0] : pry;
        q_x[s]   <= {pqx[QW-2:0], gex};
        q_y[s]   <= {pqy[QW-2:0], gey};
        den[s]   <= pden;
        tag[s]   <= ptag;
        org_x[s] <= pox;
        org_y[s] <= poy;
      end
    end
  end

  assign out_valid = v[QW-1];
  assign out_q_x   = q_x[QW-1];
  assign out_q_y   = q_y[QW-1];
  assign out_tag   = tag[QW-1];
  assign out_org_x = org_x[QW-1];
  assign out_org_y = org_y[QW-1];

endmodule

>>> design/ray_segment_intersection_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_segment_intersection_unit
// 2D ray against line segment test in exact fixed point, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_ready) carries one ray (origin, direction)
//   and one segment (start, end) per transaction, signed fixed point.
//   Output channel (out_valid / out_ready) returns status (hit, parallel or
//   miss) and the hit point, rounded to nearest and saturated; the point
//   reads zero unless the status is hit.
//   The pipeline has seven front stages, one divider stage per quotient bit
//   (COORD_WIDTH + 2) and the output register. The divider sets the depth.
//   Throughput is one transaction per cycle while the receiver takes them.
//   Every stage holds its own valid bit and loads whenever it is empty or its
//   successor moves, so a stalled receiver only backs up the pipeline; input
//   is still taken until every stage is full. Nothing is dropped or repeated.
//   cfg_wr_en / cfg_wr_data write the parallel threshold; write
//   it only while the unit is empty.
//   Reset (rst, synchronous) empties the pipeline and sets the threshold to
//   its default of 43.
// ----------------------------------------------------------------------------
module ray_segment_intersection_unit
  import rsi_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [THR_WIDTH-1:0]          cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] ray_origin_x,
  input  logic signed [COORD_WIDTH-1:0] ray_origin_y,
  input  logic signed [COORD_WIDTH-1:0] ray_dir_x,
  input  logic signed [COORD_WIDTH-1:0] ray_dir_y,
  input  logic signed [COORD_WIDTH-1:0] seg_start_x,
  input  logic signed [COORD_WIDTH-1:0] seg_start_y,
  input  logic signed [COORD_WIDTH-1:0] seg_end_x,
  input  logic signed [COORD_WIDTH-1:0] seg_end_y,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    status,
  output logic signed [COORD_WIDTH-1:0] hit_x,
  output logic signed [COORD_WIDTH-1:0] hit_y
);

  localparam int W  = COORD_WIDTH;
  localparam int DM = 2 * W + 1;        // |det|, |un|
  localparam int TM = 2 * W + 2;        // |tn|
  localparam int L  = (TM + 2) / 3;     // chunk of |tn| per partial product
  localparam int PW = 3 * W + 1;        // |dir * tn|
  localparam int NW = 3 * W + 2;        // rounding numerator
  localparam int DW = 2 * W + 2;        // rounding denominator
  localparam int QW = W + 2;            // quotient incl. overflow bit
  localparam int SW = W + 3;            // origin plus quotient

  // threshold register
  logic [THR_WIDTH-1:0] threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THR_RESET;
    end else if (cfg_wr_en) begin
      threshold <= cfg_wr_data;
    end
  end

  // stage enables: load when empty or when the next stage moves
  logic v1, v2, v3, v4, v5, v6, v7;
  logic en1, en2, en3, en4, en5, en6, en7, en_o;
  logic div_in_ready, div_out_valid;

  assign en1      = !v1 || en2;
  assign en2      = !v2 || en3;
  assign en3      = !v3 || en4;
  assign en4      = !v4 || en5;
  assign en5      = !v5 || en6;
  assign en6      = !v6 || en7;
  assign en7      = !v7 || div_in_ready;
  assign en_o     = !out_valid || out_ready;
  assign in_ready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0;
      v5 <= 1'b0; v6 <= 1'b0; v7 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en1)  v1 <= in_valid;
      if (en2)  v2 <= v1;
      if (en3)  v3 <= v2;
      if (en4)  v4 <= v3;
      if (en5)  v5 <= v4;
      if (en6)  v6 <= v5;
      if (en7)  v7 <= v6;
      if (en_o) out_valid <= div_out_valid;
    end
  end

  // stage 1: segment vector and origin relative to segment start
  logic signed [W-1:0] dx1, dy1, ox01, oy01;
  logic signed [W:0]   sdx1, sdy1, ox1, oy1;

  always_ff @(posedge clk) begin
    if (en1 && in_valid) begin
      dx1  <= ray_dir_x;
      dy1  <= ray_dir_y;
      ox01 <= ray_origin_x;
      oy01 <= ray_origin_y;
      sdx1 <= (W+1)'(seg_end_x) - (W+1)'(seg_start_x);
      sdy1 <= (W+1)'(seg_end_y) - (W+1)'(seg_start_y);
      ox1  <= (W+1)'(ray_origin_x) - (W+1)'(seg_start_x);
      oy1  <= (W+1)'(ray_origin_y) - (W+1)'(seg_start_y);
    end
  end

  // stage 2: the six products behind the three cross products
  logic signed [W-1:0] dx2, dy2, ox02, oy02;
  logic signed [2*W:0] mdet_a, mdet_b, mun_a, mun_b;
  logic signed [TM-1:0] mtn_a, mtn_b;

  always_ff @(posedge clk) begin
    if (en2 && v1) begin
      dx2    <= dx1;
      dy2    <= dy1;
      ox02   <= ox01;
      oy02   <= oy01;
      mdet_a <= dy1 * sdx1;
      mdet_b <= dx1 * sdy1;
      mun_a  <= dy1 * ox1;
      mun_b  <= dx1 * oy1;
      mtn_a  <= sdy1 * ox1;
      mtn_b  <= sdx1 * oy1;
    end
  end

  // stage 3: determinant and the two numerators
  logic signed [W-1:0]    dx3, dy3, ox03, oy03;
  logic signed [2*W+1:0]  det3, un3;
  logic signed [TM:0]     tn3;

  always_ff @(posedge clk) begin
    if (en3 && v2) begin
      dx3  <= dx2;
      dy3  <= dy2;
      ox03 <= ox02;
      oy03 <= oy02;
      det3 <= (2*W+2)'(mdet_a) - (2*W+2)'(mdet_b);
      un3  <= (2*W+2)'(mun_a) - (2*W+2)'(mun_b);
      tn3  <= (TM+1)'(mtn_a) - (TM+1)'(mtn_b);
    end
  end

  // stage 4: classify and take magnitudes
  logic [DM-1:0] det_abs, un_abs;
  logic [TM-1:0] tn_abs;
  logic          det_neg, un_neg, tn_neg;
  logic          parallel, t_ok, u_ok;
  logic [1:0]    status_next;

  always_comb begin
    det_neg  = det3[2*W+1];
    un_neg   = un3[2*W+1];
    tn_neg   = tn3[TM];
    det_abs  = det_neg ? DM'(-det3) : DM'(det3);
    un_abs   = un_neg  ? DM'(-un3)  : DM'(un3);
    tn_abs   = tn_neg  ? TM'(-tn3)  : TM'(tn3);
    parallel = det_abs <= DM'(threshold);
    // inclusive bounds: zero numerators count as on the ray or segment
    t_ok     = (tn3 == '0) || (tn_neg == det_neg);
    u_ok     = ((un3 == '0) || (un_neg == det_neg)) && (un_abs <= det_abs);
    if (parallel) begin
      status_next = ST_PARALLEL;
    end else if (t_ok && u_ok) begin
      status_next = ST_HIT;
    end else begin
      status_next = ST_MISS;
    end
  end

  logic [W-1:0]        dxm4, dym4;
  logic signed [W-1:0] ox04, oy04;
  logic [DM-1:0]       det_m4;
  logic [TM-1:0]       tn_m4;
  rsi_tag_t            tag4;

  always_ff @(posedge clk) begin
    if (en4 && v3) begin
      dxm4         <= dx3[W-1] ? W'(-dx3) : W'(dx3);
      dym4         <= dy3[W-1] ? W'(-dy3) : W'(dy3);
      ox04         <= ox03;
      oy04         <= oy03;
      det_m4       <= det_abs;
      tn_m4        <= tn_abs;
      tag4.status  <= status_next;
      tag4.neg_x   <= dx3[W-1] ^ tn_neg ^ det_neg;
      tag4.neg_y   <= dy3[W-1] ^ tn_neg ^ det_neg;
    end
  end

  // stage 5: partial products of |dir| and |tn| in three chunks
  logic [3*L-1:0]      tn_pad;
  logic [W+L-1:0]      pp_x [3];
  logic [W+L-1:0]      pp_y [3];
  logic signed [W-1:0] ox05, oy05;
  logic [DM-1:0]       det_m5;
  rsi_tag_t            tag5;

  assign tn_pad = (3*L)'(tn_m4);

  always_ff @(posedge clk) begin
    if (en5 && v4) begin
      for (int j = 0; j < 3; j++) begin
        pp_x[j] <= dxm4 * tn_pad[j*L +: L];
        pp_y[j] <= dym4 * tn_pad[j*L +: L];
      end
      ox05   <= ox04;
      oy05   <= oy04;
      det_m5 <= det_m4;
      tag5   <= tag4;
    end
  end

  // stage 6: combine partial products
  logic [PW-1:0]       p_x6, p_y6;
  logic signed [W-1:0] ox06, oy06;
  logic [DM-1:0]       det_m6;
  rsi_tag_t            tag6;

  always_ff @(posedge clk) begin
    if (en6 && v5) begin
      p_x6   <= PW'(pp_x[0]) + (PW'(pp_x[1]) << L) + (PW'(pp_x[2]) << (2*L));
      p_y6   <= PW'(pp_y[0]) + (PW'(pp_y[1]) << L) + (PW'(pp_y[2]) << (2*L));
      ox06   <= ox05;
      oy06   <= oy05;
      det_m6 <= det_m5;
      tag6   <= tag5;
    end
  end

  // stage 7: round to nearest, ties away: (2|p| + |det|) / (2|det|)
  logic [NW-1:0]       num_x7, num_y7;
  logic [DW-1:0]       den7;
  logic signed [W-1:0] ox07, oy07;
  rsi_tag_t            tag7;

  always_ff @(posedge clk) begin
    if (en7 && v6) begin
      num_x7 <= NW'({p_x6, 1'b0}) + NW'(det_m6);
      num_y7 <= NW'({p_y6, 1'b0}) + NW'(det_m6);
      den7   <= {det_m6, 1'b0};
      ox07   <= ox06;
      oy07   <= oy06;
      tag7   <= tag6;
    end
  end

  // divider
  logic [QW-1:0]       q_x, q_y;
  rsi_tag_t            tag_d;
  logic signed [W-1:0] ox0d, oy0d;

  rsi_div_pipe #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v7),
    .in_ready  (div_in_ready),
    .in_num_x  (num_x7),
    .in_num_y  (num_y7),
    .in_den    (den7),
    .in_tag    (tag7),
    .in_org_x  (ox07),
    .in_org_y  (oy07),
    .out_valid (div_out_valid),
    .out_ready (en_o),
    .out_q_x   (q_x),
    .out_q_y   (q_y),
    .out_tag   (tag_d),
    .out_org_x (ox0d),
    .out_org_y (oy0d)
  );

  // output stage: add the origin, saturate, zero the point unless hit
  localparam logic [W-1:0] SAT_MAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] SAT_MIN = {1'b1, {(W-1){1'b0}}};

  function automatic logic [W-1:0] place(input logic signed [W-1:0] org,
                                         input logic [QW-1:0] q,
                                         input logic neg);
    logic signed [SW-1:0] sq;
    logic signed [SW-1:0] sum;
    logic [W-1:0]         res;
    sq  = $signed({2'b00, q[QW-2:0]});
    if (neg) begin
      sq = -sq;
    end
    sum = SW'(org) + sq;
    if (q[QW-1]) begin
      res = neg ? SAT_MIN : SAT_MAX;
    end else if ((sum[SW-1:W-1] == '0) || (sum[SW-1:W-1] == '1)) begin
      res = sum[W-1:0];
    end else begin
      res = sum[SW-1] ? SAT_MIN : SAT_MAX;
    end
    return res;
  endfunction

  always_ff @(posedge clk) begin
    if (en_o && div_out_valid) begin
      status <= tag_d.status;
      if (tag_d.status == ST_HIT) begin
        hit_x <= place(ox0d, q_x, tag_d.neg_x);
        hit_y <= place(oy0d, q_y, tag_d.neg_y);
      end else begin
        hit_x <= '0;
        hit_y <= '0;
      end
    end
  end

  // checks
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_HIT) |-> (hit_x == '0) && (hit_y == '0))
    else $error("non-hit result carries a point");

  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input held off while pipeline has room");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result presented straight after reset");

endmodule
